// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the session summary RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every edge outside reset
`define SPS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Expression must never be true outside reset
`define SPS_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SPS_ASSERT(label, clk, rst, prop, msg)
`define SPS_NEVER(label, clk, rst, expr, msg)
`endif

`endif

// ----- rtl/core/sps_pkg.sv -----
// ----------------------------------------------------------------------------
// sps_pkg
// Types, constants and the log2 mantissa table of the session price summary.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sps_pkg;

  // Field and datapath widths
  localparam int PRICE_W    = 40;
  localparam int NORM_W     = 39;
  localparam int EXP_W      = 6;
  localparam int LOG_W      = 36;
  localparam int TAB_W      = 31;
  localparam int Q_FRAC     = 30;
  localparam int WORD_W     = 64;
  localparam int CNT_W      = 6;
  localparam int STEP_W     = 16;
  localparam int NUM_W      = 16;
  localparam int SECS_W     = 17;
  localparam int S_DATA_W   = 208;
  localparam int M_DATA_W   = 296;

  // Log table geometry
  localparam int LOG_TABLE_BITS = 8;
  localparam int LOG_TABLE_SIZE = (1 << LOG_TABLE_BITS) + 1;
  localparam int FRAC_SHIFT     = Q_FRAC - LOG_TABLE_BITS;

  // Arithmetic constants
  localparam logic [WORD_W-1:0] LN2_Q32   = 64'd2977044472;
  localparam logic [WORD_W-1:0] BPS_SCALE = 64'd10000;
  localparam logic [WORD_W-1:0] Q30_ONE   = 64'd1 << Q_FRAC;
  localparam logic [EXP_W-1:0]  EXP_TOP   = EXP_W'(NORM_W - 1);

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

  typedef struct packed {
    logic              start;
    logic [NORM_W-1:0] value;
  } nrm_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [EXP_W-1:0]  e;
    logic [NORM_W-1:0] mant;
  } nrm_out_t;

  typedef logic [LOG_TABLE_SIZE-1:0][TAB_W-1:0] log_tab_t;

  // log2 of a Q30 mantissa in [1,2) by repeated squaring
  function automatic logic [TAB_W-1:0] mant_log2(input logic [WORD_W-1:0] x_in);
    logic [WORD_W-1:0] x;
    logic [TAB_W-1:0]  r;
    x = x_in;
    r = '0;
    for (int k = 0; k < Q_FRAC; k++) begin
      x = (x * x) >> Q_FRAC;
      r = {r[TAB_W-2:0], 1'b0};
      if (x >= (Q30_ONE << 1)) begin
        x = x >> 1;
        r[0] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic log_tab_t build_tab();
    log_tab_t t;
    for (int i = 0; i < LOG_TABLE_SIZE - 1; i++) begin
      t[i] = mant_log2(Q30_ONE + (WORD_W'(i) << FRAC_SHIFT));
    end
    t[LOG_TABLE_SIZE-1] = Q30_ONE[TAB_W-1:0];
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_tab();

endpackage

`default_nettype wire

// ----- rtl/core/session_price_summary.sv -----
// ----------------------------------------------------------------------------
// session_price_summary
// Per-session high/low/close, realized variance of bps log returns and VWAP.
// ----------------------------------------------------------------------------
// One grid point is taken at a time; s_axis_tready is high only while idle.
// An absent or non-positive point ends the return chain and goes straight to
// the tail state. A valid point runs a leading-one search and an
// interpolation multiply on the shared bit-serial unit; when it continues a
// return chain it adds three more multiplies (ln scaling, bps scaling,
// squaring). The session-end point adds a divide when the volume is
// positive, and then loads the output register. The shared unit handles one
// bit per cycle. A finished summary waits in the output register while the
// next session's points are taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module session_price_summary (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // tdata: mid_price[39:0], notional_sum[103:40], volume_sum[167:104],
  //        session_number[183:168], session_seconds[200:184], zero pad
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [sps_pkg::S_DATA_W-1:0]    s_axis_tdata,
  // tuser: point_present[0]
  input  wire logic [0:0]                      s_axis_tuser,
  input  wire logic                            s_axis_tlast,
  // tdata: out_session_number[15:0], out_session_seconds[32:16],
  //        high_price[71:33], low_price[110:72], close_price[149:111],
  //        sum_sq_return[213:150], step_count[229:214], vwap_price[293:230],
  //        zero pad
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [sps_pkg::M_DATA_W-1:0]         m_axis_tdata,
  // tuser: any_present[0], vwap_valid[1]
  output logic [1:0]                           m_axis_tuser
);

  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_LOGMUL,
    ST_DIFF,
    ST_LNMUL,
    ST_BPSMUL,
    ST_SQMUL,
    ST_TAIL,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t state;

  // Captured request
  logic                         in_last;
  logic [sps_pkg::WORD_W-1:0]   in_notional;
  logic [sps_pkg::WORD_W-1:0]   in_volume;
  logic [sps_pkg::NUM_W-1:0]    in_num;
  logic [sps_pkg::SECS_W-1:0]   in_secs;

  // Session state
  logic                         chain_open;
  logic                         seen_any;
  logic [sps_pkg::NORM_W-1:0]   running_high;
  logic [sps_pkg::NORM_W-1:0]   running_low;
  logic [sps_pkg::NORM_W-1:0]   latest_price;
  logic [sps_pkg::WORD_W-1:0]   square_sum;
  logic [sps_pkg::STEP_W-1:0]   steps_seen;
  logic [sps_pkg::LOG_W-1:0]    prev_log;
  logic [sps_pkg::LOG_W-1:0]    log_base;
  logic [sps_pkg::LOG_W-1:0]    cur_log;

  // Output register
  logic [sps_pkg::NUM_W-1:0]    out_session_number;
  logic [sps_pkg::SECS_W-1:0]   out_session_seconds;
  logic                         any_present;
  logic [sps_pkg::NORM_W-1:0]   high_price;
  logic [sps_pkg::NORM_W-1:0]   low_price;
  logic [sps_pkg::NORM_W-1:0]   close_price;
  logic [sps_pkg::WORD_W-1:0]   sum_sq_return;
  logic [sps_pkg::STEP_W-1:0]   step_count;
  logic                         vwap_valid;
  logic [sps_pkg::WORD_W-1:0]   vwap_price;

  // Shared units
  sps_pkg::alu_req_t            alu_req;
  sps_pkg::alu_stat_t           alu_stat;
  logic [2*sps_pkg::WORD_W-1:0] alu_res;
  sps_pkg::nrm_req_t            nrm_req;
  sps_pkg::nrm_out_t            nrm_out;

  sps_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .stat   (alu_stat),
    .result (alu_res)
  );

  sps_norm u_norm (
    .clk  (clk),
    .rst  (rst),
    .req  (nrm_req),
    .nout (nrm_out)
  );

  // Incoming point qualification
  logic                         s_fire;
  logic [sps_pkg::PRICE_W-1:0]  s_price;
  logic                         s_valid_pt;
  logic [sps_pkg::NORM_W-1:0]   s_p39;

  assign s_fire     = s_axis_tvalid & s_axis_tready;
  assign s_price    = s_axis_tdata[sps_pkg::PRICE_W-1:0];
  assign s_p39      = s_price[sps_pkg::NORM_W-1:0];
  assign s_valid_pt = s_axis_tuser[0] & ~s_price[sps_pkg::PRICE_W-1] & (|s_p39);

  // Table lookup from the normalized mantissa
  logic [sps_pkg::Q_FRAC-1:0]         f30;
  logic [sps_pkg::LOG_TABLE_BITS:0]   tab_lo_i;
  logic [sps_pkg::LOG_TABLE_BITS:0]   tab_hi_i;
  logic [sps_pkg::TAB_W-1:0]          tab_lo_v;
  logic [sps_pkg::TAB_W-1:0]          tab_hi_v;
  logic [sps_pkg::FRAC_SHIFT-1:0]     frac_rem;

  assign f30      = nrm_out.mant[sps_pkg::NORM_W-2 -: sps_pkg::Q_FRAC];
  assign tab_lo_i = {1'b0, f30[sps_pkg::Q_FRAC-1 -: sps_pkg::LOG_TABLE_BITS]};
  assign tab_hi_i = tab_lo_i + 1'b1;
  assign tab_lo_v = sps_pkg::LOG_TAB[tab_lo_i];
  assign tab_hi_v = sps_pkg::LOG_TAB[tab_hi_i];
  assign frac_rem = f30[sps_pkg::FRAC_SHIFT-1:0];

  // Result picks from the shared unit
  logic [sps_pkg::LOG_W-1:0]    log_full;
  logic [sps_pkg::LOG_W-1:0]    log_diff;
  logic [sps_pkg::WORD_W-1:0]   sq_term;
  logic [sps_pkg::WORD_W:0]     sq_acc;
  logic                         vol_pos;
  logic [sps_pkg::WORD_W-1:0]   notional_mag;

  assign log_full = log_base + sps_pkg::LOG_W'(alu_res[sps_pkg::FRAC_SHIFT +: sps_pkg::TAB_W]);
  assign log_diff = (cur_log >= prev_log) ? (cur_log - prev_log) : (prev_log - cur_log);
  assign sq_term  = (|alu_res[2*sps_pkg::WORD_W-1:sps_pkg::WORD_W+40]) ? '1
                                                                       : alu_res[40 +: 64];
  assign sq_acc   = {1'b0, square_sum} + {1'b0, sq_term};
  assign vol_pos  = ~in_volume[sps_pkg::WORD_W-1] & (|in_volume);
  assign notional_mag = in_notional[sps_pkg::WORD_W-1] ? (~in_notional + 1'b1) : in_notional;

  // Launch the shared units on the cycle their operands are loaded
  logic                         alu_start_next;
  logic                         nrm_start_next;

  always_comb begin
    nrm_start_next = (state == ST_IDLE) && s_fire && s_valid_pt;
    case (state)
      ST_NORM:            alu_start_next = nrm_out.done;
      ST_DIFF:            alu_start_next = 1'b1;
      ST_LNMUL, ST_BPSMUL: alu_start_next = alu_stat.done;
      ST_TAIL:            alu_start_next = in_last && vol_pos;
      default:            alu_start_next = 1'b0;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      chain_open    <= 1'b0;
      seen_any      <= 1'b0;
      running_high  <= '0;
      running_low   <= '0;
      latest_price  <= '0;
      square_sum    <= '0;
      steps_seen    <= '0;
      m_axis_tvalid <= 1'b0;
      alu_req.start <= 1'b0;
      nrm_req.start <= 1'b0;
    end else begin
      alu_req.start <= alu_start_next;
      nrm_req.start <= nrm_start_next;
      // drop the summary once taken, unless a new one loads now
      if (m_axis_tvalid && m_axis_tready && state != ST_EMIT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            in_last     <= s_axis_tlast;
            in_notional <= s_axis_tdata[40 +: 64];
            in_volume   <= s_axis_tdata[104 +: 64];
            in_num      <= s_axis_tdata[168 +: 16];
            in_secs     <= s_axis_tdata[184 +: 17];
            if (s_valid_pt) begin
              // update high, low and close, then start the log
              if (!seen_any || s_p39 > running_high) running_high <= s_p39;
              if (!seen_any || s_p39 < running_low) running_low <= s_p39;
              latest_price  <= s_p39;
              seen_any      <= 1'b1;
              nrm_req.value <= s_p39;
              state         <= ST_NORM;
            end else begin
              chain_open <= 1'b0;
              state      <= ST_TAIL;
            end
          end
        end
        ST_NORM: begin
          if (nrm_out.done) begin
            log_base      <= {nrm_out.e, {sps_pkg::Q_FRAC{1'b0}}}
                             + sps_pkg::LOG_W'(tab_lo_v);
            alu_req.op    <= sps_pkg::ALU_MUL;
            alu_req.a     <= sps_pkg::WORD_W'(tab_hi_v - tab_lo_v);
            alu_req.b     <= sps_pkg::WORD_W'(frac_rem);
            state         <= ST_LOGMUL;
          end
        end
        ST_LOGMUL: begin
          if (alu_stat.done) begin
            if (chain_open) begin
              cur_log <= log_full;
              state   <= ST_DIFF;
            end else begin
              prev_log   <= log_full;
              chain_open <= 1'b1;
              state      <= ST_TAIL;
            end
          end
        end
        ST_DIFF: begin
          alu_req.op    <= sps_pkg::ALU_MUL;
          alu_req.a     <= sps_pkg::WORD_W'(log_diff);
          alu_req.b     <= sps_pkg::LN2_Q32;
          state         <= ST_LNMUL;
        end
        ST_LNMUL: begin
          if (alu_stat.done) begin
            alu_req.a     <= sps_pkg::WORD_W'(alu_res[32 +: sps_pkg::LOG_W]);
            alu_req.b     <= sps_pkg::BPS_SCALE;
            state         <= ST_BPSMUL;
          end
        end
        ST_BPSMUL: begin
          if (alu_stat.done) begin
            alu_req.a     <= alu_res[sps_pkg::WORD_W-1:0];
            alu_req.b     <= alu_res[sps_pkg::WORD_W-1:0];
            state         <= ST_SQMUL;
          end
        end
        ST_SQMUL: begin
          if (alu_stat.done) begin
            // saturating accumulate of the squared return
            square_sum <= sq_acc[sps_pkg::WORD_W] ? '1 : sq_acc[sps_pkg::WORD_W-1:0];
            if (steps_seen != '1) steps_seen <= steps_seen + 1'b1;
            prev_log   <= cur_log;
            chain_open <= 1'b1;
            state      <= ST_TAIL;
          end
        end
        ST_TAIL: begin
          if (!in_last) begin
            state <= ST_IDLE;
          end else if (vol_pos) begin
            alu_req.op    <= sps_pkg::ALU_DIV;
            alu_req.a     <= notional_mag;
            alu_req.b     <= in_volume;
            state         <= ST_DIV;
          end else begin
            vwap_price <= '0;
            state      <= ST_EMIT;
          end
        end
        ST_DIV: begin
          if (alu_stat.done) begin
            vwap_price <= in_notional[sps_pkg::WORD_W-1]
                          ? (~alu_res[sps_pkg::WORD_W-1:0] + 1'b1)
                          : alu_res[sps_pkg::WORD_W-1:0];
            state      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // load the summary once the output register is free, then clear
          if (!m_axis_tvalid || m_axis_tready) begin
            out_session_number  <= in_num;
            out_session_seconds <= in_secs;
            any_present         <= seen_any;
            high_price          <= running_high;
            low_price           <= running_low;
            close_price         <= latest_price;
            sum_sq_return       <= square_sum;
            step_count          <= steps_seen;
            vwap_valid          <= vol_pos;
            m_axis_tvalid       <= 1'b1;
            chain_open          <= 1'b0;
            seen_any            <= 1'b0;
            running_high        <= '0;
            running_low         <= '0;
            latest_price        <= '0;
            square_sum          <= '0;
            steps_seen          <= '0;
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tdata  = {2'b00, vwap_price, step_count, sum_sq_return, close_price,
                          low_price, high_price, out_session_seconds, out_session_number};
  assign m_axis_tuser  = {vwap_valid, any_present};

  `SPS_ASSERT(a_idle_units_quiet, clk, rst, s_axis_tready |-> !alu_stat.busy && !nrm_out.busy, "shared unit busy while idle")
  `SPS_ASSERT(a_steps_need_point, clk, rst, (steps_seen != '0) |-> seen_any, "return step counted without a point")
  `SPS_ASSERT(a_low_not_above_high, clk, rst, seen_any |-> (running_low <= running_high), "running low above running high")

endmodule

`default_nettype wire

// ----- rtl/core/sps_alu.sv -----
// ----------------------------------------------------------------------------
// sps_alu
// Shared bit-serial unit: 64x64 shift-add multiply or 64/64 restoring divide,
// one bit per cycle on a single 65-bit adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sps_alu (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire sps_pkg::alu_req_t           req,
  output sps_pkg::alu_stat_t               stat,
  output logic [2*sps_pkg::WORD_W-1:0]     result
);

  logic [sps_pkg::WORD_W:0]     hi;
  logic [sps_pkg::WORD_W-1:0]   lo;
  logic [sps_pkg::WORD_W-1:0]   opnd;
  sps_pkg::alu_op_t             op;
  logic [sps_pkg::CNT_W-1:0]    cnt;
  logic                         busy;
  logic                         done;

  logic [sps_pkg::WORD_W:0]     add_x;
  logic [sps_pkg::WORD_W:0]     add_y;
  logic                         add_cin;
  logic [sps_pkg::WORD_W+1:0]   sum;

  // Select adder operands: accumulate for multiply, trial subtract for divide
  always_comb begin
    if (op == sps_pkg::ALU_MUL) begin
      add_x   = hi;
      add_y   = {1'b0, lo[0] ? opnd : '0};
      add_cin = 1'b0;
    end else begin
      add_x   = {hi[sps_pkg::WORD_W-1:0], lo[sps_pkg::WORD_W-1]};
      add_y   = ~{1'b0, opnd};
      add_cin = 1'b1;
    end
    sum = {1'b0, add_x} + {1'b0, add_y} + {{(sps_pkg::WORD_W+1){1'b0}}, add_cin};
  end

  // Iterate one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        op   <= req.op;
        hi   <= '0;
        lo   <= (req.op == sps_pkg::ALU_MUL) ? req.b : req.a;
        opnd <= (req.op == sps_pkg::ALU_MUL) ? req.a : req.b;
      end else if (busy) begin
        if (op == sps_pkg::ALU_MUL) begin
          hi <= {1'b0, sum[sps_pkg::WORD_W:1]};
          lo <= {sum[0], lo[sps_pkg::WORD_W-1:1]};
        end else begin
          hi <= sum[sps_pkg::WORD_W+1] ? sum[sps_pkg::WORD_W:0] : add_x;
          lo <= {lo[sps_pkg::WORD_W-2:0], sum[sps_pkg::WORD_W+1]};
        end
        cnt <= cnt + 1'b1;
        if (cnt == {sps_pkg::CNT_W{1'b1}}) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  // Product is {hi, lo}; quotient is lo
  assign result = (op == sps_pkg::ALU_MUL) ? {hi[sps_pkg::WORD_W-1:0], lo}
                                           : {{sps_pkg::WORD_W{1'b0}}, lo};

endmodule

`default_nettype wire

// ----- rtl/core/sps_norm.sv -----
// ----------------------------------------------------------------------------
// sps_norm
// Iterative leading-one search: shifts a positive price left one bit per
// cycle until its top bit is set, counting down the exponent.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sps_norm (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sps_pkg::nrm_req_t req,
  output sps_pkg::nrm_out_t      nout
);

  logic [sps_pkg::NORM_W-1:0] mant;
  logic [sps_pkg::EXP_W-1:0]  e;
  logic                       busy;
  logic                       at_top;

  assign at_top = mant[sps_pkg::NORM_W-1];

  // Shift until normalized
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      mant <= req.value;
      e    <= sps_pkg::EXP_TOP;
    end else if (busy) begin
      if (at_top) begin
        busy <= 1'b0;
      end else begin
        mant <= {mant[sps_pkg::NORM_W-2:0], 1'b0};
        e    <= e - 1'b1;
      end
    end
  end

  assign nout.busy = busy;
  assign nout.done = busy & at_top;
  assign nout.e    = e;
  assign nout.mant = mant;

endmodule

`default_nettype wire
